/* rtl/oims_pkg.sv */
// ----------------------------------------------------------------------------
// oims_pkg
// shared types and defaults for the odd-only sort core
// ----------------------------------------------------------------------------
package oims_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int DATA_BITS_DEF = 16;

	// operation applied to every cell of the sort chain in the same cycle
	typedef struct packed {
		logic insert;
		logic pop;
		logic clear;
	} chain_ctrl_t;

endpackage

/* rtl/oims_cell.sv */
// ----------------------------------------------------------------------------
// oims_cell
// one slot of the insertion sort chain, ascending from the head
// ----------------------------------------------------------------------------
module oims_cell #(
	parameter int DATA_BITS = oims_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  oims_pkg::chain_ctrl_t       ctrl,
	input  logic signed [DATA_BITS-1:0] new_value,
	input  logic signed [DATA_BITS-1:0] left_value,
	input  logic                        left_valid,
	input  logic                        left_gt,
	input  logic signed [DATA_BITS-1:0] right_value,
	input  logic                        right_valid,
	output logic signed [DATA_BITS-1:0] value,
	output logic                        valid,
	output logic                        gt
);

	logic signed [DATA_BITS-1:0] value_q;
	logic                        valid_q;

	// empty slots act as plus infinity
	assign gt    = !valid_q || (new_value < value_q);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.insert && gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			value_q <= right_value;
		end else if (ctrl.insert && gt) begin
			// shift right when the left neighbor also yields, else take the new value
			value_q <= left_gt ? left_value : new_value;
		end
	end

endmodule

/* rtl/oims_sort_chain.sv */
// ----------------------------------------------------------------------------
// oims_sort_chain
// row of cells holding the odd values in ascending order
// ----------------------------------------------------------------------------
module oims_sort_chain #(
	parameter int MAX_ITEMS = oims_pkg::MAX_ITEMS_DEF,
	parameter int DATA_BITS = oims_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  oims_pkg::chain_ctrl_t       ctrl,
	input  logic signed [DATA_BITS-1:0] new_value,
	output logic signed [DATA_BITS-1:0] head_value
);

	logic signed [DATA_BITS-1:0] value [MAX_ITEMS];
	logic                        valid [MAX_ITEMS];
	logic                        gt    [MAX_ITEMS];

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [DATA_BITS-1:0] l_value;
		logic                        l_valid;
		logic                        l_gt;
		logic signed [DATA_BITS-1:0] r_value;
		logic                        r_valid;

		if (i == 0) begin : g_head
			assign l_value = new_value;
			assign l_valid = 1'b1;
			assign l_gt    = 1'b0;
		end else begin : g_body
			assign l_value = value[i-1];
			assign l_valid = valid[i-1];
			assign l_gt    = gt[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign r_value = value[i];
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_value = value[i+1];
			assign r_valid = valid[i+1];
		end

		oims_cell #(
			.DATA_BITS(DATA_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_value  (new_value),
			.left_value (l_value),
			.left_valid (l_valid),
			.left_gt    (l_gt),
			.right_value(r_value),
			.right_valid(r_valid),
			.value      (value[i]),
			.valid      (valid[i]),
			.gt         (gt[i])
		);
	end

	assign head_value = value[0];

endmodule

/* rtl/oims_store.sv */
// ----------------------------------------------------------------------------
// oims_store
// element memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module oims_store #(
	parameter int MAX_ITEMS = oims_pkg::MAX_ITEMS_DEF,
	parameter int DATA_BITS = oims_pkg::DATA_BITS_DEF,
	localparam int IDX_W    = $clog2(MAX_ITEMS)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic [IDX_W-1:0]     rd_addr,
	output logic [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem [MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/odd_only_inplace_merge_sort_core.sv */
// ----------------------------------------------------------------------------
// odd_only_inplace_merge_sort_core
// sorts the odd elements of a batch in place, even elements keep their slots
// ----------------------------------------------------------------------------
//
// channel  dir  transaction carries
// -------  ---  ---------------------------------------------------------
// s_*      in   one element (tdata) and end of batch (tlast)
// m_*      out  element after sorting (tdata), last of batch (tlast),
//               overflow seen in this batch (tuser)
//
// flow: loading accepts one element per cycle; each odd element is placed in
//   the sort chain as it arrives, so no sorting pass follows the last element
// emission steps through a memory read, a merge with the chain head and a
//   handshake for each result
// reset: arst_n clears the control state and empties the chain; the element
//   memory is not cleared
// stalls: input is refused while a batch is emitted; m_tready low holds the
//   current result and freezes the emission sequence
//
module odd_only_inplace_merge_sort_core #(
	parameter int MAX_ITEMS = oims_pkg::MAX_ITEMS_DEF,
	parameter int DATA_BITS = oims_pkg::DATA_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((DATA_BITS+7)/8)*8-1:0]     s_tdata,  // sample
	input  logic                               s_tlast,  // final_item
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [((DATA_BITS+7)/8)*8-1:0]     m_tdata,  // sorted_value
	output logic                               m_tlast,  // end_of_run
	output logic                               m_tuser   // overflowed
);

	import oims_pkg::*;

	localparam int IDX_W   = $clog2(MAX_ITEMS);
	localparam int COUNT_W = $clog2(MAX_ITEMS + 1);
	localparam int TDATA_W = ((DATA_BITS + 7) / 8) * 8;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_READ = 4'b0010,
		ST_SHOW = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t                state_q;
	logic [COUNT_W-1:0]    count_q;     // elements held in this batch
	logic                  ovf_q;       // set when an element was dropped in this batch
	logic [IDX_W-1:0]      rd_idx_q;    // position being emitted
	logic [DATA_BITS-1:0]  out_data_q;
	logic                  out_last_q;
	logic                  out_user_q;
	logic                  m_valid_q;

	logic                  s_acc;
	logic                  m_acc;
	logic                  has_room;
	logic [DATA_BITS-1:0]  sample;
	logic [DATA_BITS-1:0]  rd_data;
	logic signed [DATA_BITS-1:0] head_value;
	logic                  is_last_pos;
	chain_ctrl_t           ctrl;

	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_valid_q && m_tready;
	assign has_room = (count_q < COUNT_W'(MAX_ITEMS));
	assign sample   = s_tdata[DATA_BITS-1:0];

	// position order is kept in memory; the odd slots are refilled from the chain head
	assign is_last_pos = ((COUNT_W'(rd_idx_q) + COUNT_W'(1)) == count_q);

	assign ctrl.insert = s_acc && has_room && sample[0];
	assign ctrl.pop    = (state_q == ST_SHOW) && rd_data[0];
	assign ctrl.clear  = m_acc && out_last_q;

	oims_store #(
		.MAX_ITEMS(MAX_ITEMS),
		.DATA_BITS(DATA_BITS)
	) u_store (
		.clk    (clk),
		.wr_en  (s_acc && has_room),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(sample),
		.rd_addr(rd_idx_q),
		.rd_data(rd_data)
	);

	oims_sort_chain #(
		.MAX_ITEMS(MAX_ITEMS),
		.DATA_BITS(DATA_BITS)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.new_value (signed'(sample)),
		.head_value(head_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			rd_idx_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (has_room) begin
							count_q <= count_q + COUNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							rd_idx_q <= '0;
							state_q  <= ST_READ;
						end
					end
				end
				ST_READ: begin
					// memory data for rd_idx_q lands next cycle
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					m_valid_q <= 1'b1;
					state_q   <= ST_HOLD;
				end
				ST_HOLD: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						if (out_last_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							rd_idx_q <= rd_idx_q + IDX_W'(1);
							state_q  <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result payload, loaded once per result and held through stalls
	always_ff @(posedge clk) begin
		if (state_q == ST_SHOW) begin
			out_data_q <= rd_data[0] ? head_value : rd_data;
			out_last_q <= is_last_pos;
			out_user_q <= ovf_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDATA_W'(out_data_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

endmodule

/* rtl/oims_checker.sv */
// ----------------------------------------------------------------------------
// oims_checker
// port-level checks on the sort core, bound to the top level
// ----------------------------------------------------------------------------
module oims_checker #(
	parameter int DATA_BITS = oims_pkg::DATA_BITS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [((DATA_BITS+7)/8)*8-1:0] m_tdata,
	input logic                           m_tlast,
	input logic                           m_tuser
);

	// a stalled result stays offered with the same payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result dropped or changed while stalled");

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is offered");

	// end of batch closes the input
	a_batch_close: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still open after end of batch");

	// last result reopens the input
	a_batch_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("input not reopened after last result");

endmodule

bind odd_only_inplace_merge_sort_core oims_checker #(
	.DATA_BITS(DATA_BITS)
) u_oims_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);
